// ----- design/wpcm_pkg.sv -----
// shared types and constants for the wave pcm chunk parser
package wpcm_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [33:0] SEEN_MAX = 34'h3FFFFFFFF;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_HDR   = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_OVERRUN   = 3'd3;
   localparam logic [2:0] ST_BAD_FMT   = 3'd4;
   localparam logic [2:0] ST_DATA_1ST  = 3'd5;
   localparam logic [2:0] ST_NO_DATA   = 3'd6;
   localparam logic [2:0] ST_INVALID   = 3'd7;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_CHDR,
      PH_BODY,
      PH_PAD,
      PH_SAMPLES,
      PH_IDLE,
      PH_CHECK
   } phase_type;

   // one queued action from the front to the back, status fields travel along
   typedef struct packed {
      logic        emit_sample;
      logic [7:0]  sample;
      logic        emit_status;
      logic [2:0]  status;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] align;
      logic [15:0] bits;
      logic [31:0] dlen;
   } act_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SAMPLE,
      BK_STATUS
   } back_type;

endpackage

// ----- design/wpcm_front.sv -----
// front part: parses bytes and classifies them into actions
module wpcm_front #(
   parameter int FMT_MIN_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_final_byte,
   output logic              act_valid,
   input  logic              act_full,
   output wpcm_pkg::act_type act
);

   wpcm_pkg::phase_type phase_ff, phase_in;
   logic [33:0] seen_ff, seen_in, limit_ff, limit_in;
   logic [31:0] left_ff, left_in, shift_ff, shift_in, tag_ff, tag_in;
   logic [4:0]  pos_ff, pos_in;
   logic        pad_ff, pad_in, hfmt_ff, hfmt_in, hdata_ff, hdata_in;
   logic [63:0] ff_ff, ff_in;
   logic [31:0] brate_ff, brate_in, rate_ff, rate_in, len_ff, len_in;
   logic [2:0]  err_ff, err_in;
   // final byte seen on a data header, status waits for the check
   logic        fin_ff, fin_in;
   // data header check sequencer
   logic [15:0] mcnt_ff, mcnt_in;
   logic [47:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  step_ff, step_in;

   logic        take;
   logic [31:0] sh;
   logic [33:0] off;
   logic [2:0]  st;

   // stall while checking or while the queue cannot take an item
   assign req_stall = act_full || (phase_ff == wpcm_pkg::PH_CHECK);
   assign take      = req_valid && !req_stall;
   assign sh        = {req_data_byte, shift_ff[31:8]};
   assign off       = seen_ff + 34'd1;

   // next chunk helper result
   function automatic wpcm_pkg::phase_type nxt(input logic [33:0] o, input logic [33:0] l);
      return ((o + 34'd8) <= l) ? wpcm_pkg::PH_CHDR : wpcm_pkg::PH_IDLE;
   endfunction

   // main parser
   always_comb begin
      logic [31:0] lefts;
      logic [33:0] seen_n;
      phase_in = phase_ff; seen_in = seen_ff; limit_in = limit_ff; left_in = left_ff;
      shift_in = shift_ff; tag_in = tag_ff; pos_in = pos_ff; pad_in = pad_ff;
      hfmt_in = hfmt_ff; hdata_in = hdata_ff; ff_in = ff_ff; brate_in = brate_ff;
      rate_in = rate_ff; len_in = len_ff; err_in = err_ff; fin_in = fin_ff;
      mcnt_in = mcnt_ff; prod_in = prod_ff; rem_in = rem_ff; step_in = step_ff;
      act_valid = 1'b0; act = '0; lefts = left_ff - 32'd1; st = wpcm_pkg::ST_OK;
      seen_n = seen_ff;
      if (phase_ff == wpcm_pkg::PH_CHECK) begin
         // shift-add multiply rate by align, restoring remainder of len by align
         if (step_ff != 6'd0) begin
            if (step_ff > 6'd32) begin
               if (mcnt_ff[0]) prod_in = prod_ff + ({16'd0, rate_ff} << (6'd48 - step_ff));
               mcnt_in = {1'b0, mcnt_ff[15:1]};
            end else begin
               if ({16'd0, rem_ff} >= ({32'd0, ff_ff[47:32]} << (step_ff - 6'd1)))
                  rem_in = rem_ff - 32'(({32'd0, ff_ff[47:32]} << (step_ff - 6'd1)));
            end
            step_in = step_ff - 6'd1;
         end else begin
            if ({16'd0, brate_ff} != prod_ff || rem_ff != 32'd0) begin
               err_in = wpcm_pkg::ST_INVALID; phase_in = wpcm_pkg::PH_IDLE;
            end else begin
               hdata_in = 1'b1;
               phase_in = (len_ff == 32'd0) ? wpcm_pkg::PH_IDLE : wpcm_pkg::PH_SAMPLES;
            end
            if (fin_ff) begin
               if (act_full) begin
                  // hold the result until the queue has room
                  err_in = err_ff; hdata_in = hdata_ff; phase_in = wpcm_pkg::PH_CHECK;
               end else begin
                  if (seen_ff < limit_ff) st = wpcm_pkg::ST_TRUNC;
                  else if (err_in != wpcm_pkg::ST_OK) st = err_in;
                  act.emit_status = 1'b1; act.status = st;
                  act.channels = ff_ff[31:16]; act.rate = rate_ff;
                  act.align = ff_ff[47:32]; act.bits = ff_ff[63:48]; act.dlen = len_ff;
                  act_valid = 1'b1;
                  phase_in = wpcm_pkg::PH_HEAD; seen_in = '0; limit_in = '0; left_in = '0;
                  shift_in = '0; tag_in = '0; pos_in = '0; pad_in = 1'b0; hfmt_in = 1'b0;
                  hdata_in = 1'b0; ff_in = '0; brate_in = '0; rate_in = '0; len_in = '0;
                  err_in = wpcm_pkg::ST_OK; fin_in = 1'b0;
               end
            end
         end
      end else if (take) begin
         case (phase_ff)
            wpcm_pkg::PH_HEAD: begin
               shift_in = sh; pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd3 && sh != wpcm_pkg::TAG_RIFF) begin
                  err_in = wpcm_pkg::ST_BAD_HDR; phase_in = wpcm_pkg::PH_IDLE;
               end else if (pos_ff == 5'd7) begin
                  if (sh < 32'd4) begin
                     err_in = wpcm_pkg::ST_BAD_HDR; phase_in = wpcm_pkg::PH_IDLE;
                  end else limit_in = {2'd0, sh} + 34'd8;
               end else if (pos_ff == 5'd11) begin
                  if (sh != wpcm_pkg::TAG_WAVE) begin
                     err_in = wpcm_pkg::ST_BAD_HDR; phase_in = wpcm_pkg::PH_IDLE;
                  end else begin
                     phase_in = nxt(off, limit_ff); pos_in = 5'd0;
                  end
               end
            end
            wpcm_pkg::PH_CHDR: begin
               shift_in = sh; pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd3) tag_in = sh;
               else if (pos_ff == 5'd7) begin
                  pos_in = 5'd0; left_in = sh; pad_in = sh[0];
                  if (off > limit_ff || {2'd0, sh} > (limit_ff - off)) begin
                     err_in = wpcm_pkg::ST_OVERRUN; phase_in = wpcm_pkg::PH_IDLE;
                  end else if (tag_ff == wpcm_pkg::TAG_FMT) begin
                     if (hfmt_ff || sh < 32'(FMT_MIN_BYTES)) begin
                        err_in = wpcm_pkg::ST_BAD_FMT; phase_in = wpcm_pkg::PH_IDLE;
                     end else begin
                        hfmt_in = 1'b1; phase_in = wpcm_pkg::PH_BODY;
                     end
                  end else if (tag_ff == wpcm_pkg::TAG_DATA) begin
                     len_in = sh;
                     if (!hfmt_ff) begin
                        err_in = wpcm_pkg::ST_DATA_1ST; phase_in = wpcm_pkg::PH_IDLE;
                     end else if (ff_ff[15:0] != 16'd1 || ff_ff[31:16] == 16'd0 ||
                                  rate_ff == 32'd0 || ff_ff[47:32] == 16'd0 ||
                                  ff_ff[63:48] == 16'd0) begin
                        err_in = wpcm_pkg::ST_INVALID; phase_in = wpcm_pkg::PH_IDLE;
                     end else begin
                        phase_in = wpcm_pkg::PH_CHECK; mcnt_in = ff_ff[47:32];
                        prod_in = '0; rem_in = sh; step_in = 6'd48;
                     end
                  end else if (sh == 32'd0) begin
                     if (pad_in && off < limit_ff) phase_in = wpcm_pkg::PH_PAD;
                     else phase_in = nxt(off, limit_ff);
                  end else phase_in = wpcm_pkg::PH_BODY;
               end
            end
            wpcm_pkg::PH_BODY: begin
               if (tag_ff == wpcm_pkg::TAG_FMT && pos_ff < 5'd16) begin
                  case (pos_ff[3:2])
                     2'd0: ff_in[{1'b0, pos_ff[1:0], 3'd0} +: 8] = req_data_byte;
                     2'd1: rate_in[{pos_ff[1:0], 3'd0} +: 8] = req_data_byte;
                     2'd2: brate_in[{pos_ff[1:0], 3'd0} +: 8] = req_data_byte;
                     default: ff_in[{1'b1, pos_ff[1:0], 3'd0} +: 8] = req_data_byte;
                  endcase
                  pos_in = pos_ff + 5'd1;
               end
               left_in = lefts;
               if (lefts == 32'd0) begin
                  if (pad_ff && off < limit_ff) phase_in = wpcm_pkg::PH_PAD;
                  else phase_in = nxt(off, limit_ff);
                  pos_in = 5'd0;
               end
            end
            wpcm_pkg::PH_PAD: begin
               phase_in = nxt(off, limit_ff); pos_in = 5'd0;
            end
            wpcm_pkg::PH_SAMPLES: begin
               act.emit_sample = 1'b1; act.sample = req_data_byte;
               left_in = lefts;
               if (lefts == 32'd0) phase_in = wpcm_pkg::PH_IDLE;
            end
            default: phase_in = wpcm_pkg::PH_IDLE;
         endcase
         seen_n = (seen_ff < wpcm_pkg::SEEN_MAX) ? off : seen_ff;
         seen_in = seen_n;
         if (req_final_byte) begin
            if (phase_in == wpcm_pkg::PH_CHECK) begin
               // status follows once the data header check is done
               fin_in = 1'b1;
            end else begin
               if (seen_n < 34'd12 || err_in == wpcm_pkg::ST_BAD_HDR)
                  st = wpcm_pkg::ST_BAD_HDR;
               else if (seen_n < limit_in) st = wpcm_pkg::ST_TRUNC;
               else if (err_in != wpcm_pkg::ST_OK) st = err_in;
               else if (!hdata_in) st = wpcm_pkg::ST_NO_DATA;
               act.emit_status = 1'b1; act.status = st;
               act.channels = ff_in[31:16]; act.rate = rate_in;
               act.align = ff_in[47:32]; act.bits = ff_in[63:48]; act.dlen = len_in;
               phase_in = wpcm_pkg::PH_HEAD; seen_in = '0; limit_in = '0; left_in = '0;
               shift_in = '0; tag_in = '0; pos_in = '0; pad_in = 1'b0; hfmt_in = 1'b0;
               hdata_in = 1'b0; ff_in = '0; brate_in = '0; rate_in = '0; len_in = '0;
               err_in = wpcm_pkg::ST_OK;
            end
         end
         act_valid = act.emit_sample || act.emit_status;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wpcm_pkg::PH_HEAD; seen_ff <= '0; limit_ff <= '0; left_ff <= '0;
         shift_ff <= '0; tag_ff <= '0; pos_ff <= '0; pad_ff <= 1'b0; hfmt_ff <= 1'b0;
         hdata_ff <= 1'b0; ff_ff <= '0; brate_ff <= '0; rate_ff <= '0; len_ff <= '0;
         err_ff <= wpcm_pkg::ST_OK; fin_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; seen_ff <= seen_in; limit_ff <= limit_in; left_ff <= left_in;
         shift_ff <= shift_in; tag_ff <= tag_in; pos_ff <= pos_in; pad_ff <= pad_in;
         hfmt_ff <= hfmt_in; hdata_ff <= hdata_in; ff_ff <= ff_in; brate_ff <= brate_in;
         rate_ff <= rate_in; len_ff <= len_in; err_ff <= err_in; fin_ff <= fin_in;
      end
   end

   // check datapath, no reset needed
   always_ff @(posedge clock) begin
      mcnt_ff <= mcnt_in; prod_ff <= prod_in; rem_ff <= rem_in; step_ff <= step_in;
   end

   // no item is taken while checking
   a_no_take_check: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wpcm_pkg::PH_CHECK |-> !take) else $error("take during check");
   // a final byte yields a status action unless it waits for the check
   a_final_status: assert property (@(posedge clock) disable iff (reset)
      take && req_final_byte |-> (act_valid && act.emit_status) ||
      phase_in == wpcm_pkg::PH_CHECK) else $error("no status");
   // after a final byte the parser restarts
   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && req_final_byte && phase_in != wpcm_pkg::PH_CHECK |=>
      phase_ff == wpcm_pkg::PH_HEAD && seen_ff == '0)
      else $error("no restart");

endmodule

// ----- design/wpcm_queue.sv -----
// short queue of actions between front and back
module wpcm_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wpcm_pkg::act_type push_act,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output wpcm_pkg::act_type head
);

   localparam int AW = $clog2(DEPTH);
   wpcm_pkg::act_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // pointer update
   always_comb begin
      wr_in = wr_ff; rd_in = rd_ff; cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_act;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop && !full |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count");

endmodule

// ----- design/wpcm_back.sv -----
// back part: turns queued actions into result items
module wpcm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  wpcm_pkg::act_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_item_kind,
   output logic [7:0]        rsp_sample_byte,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_channel_count,
   output logic [31:0]       rsp_sample_rate,
   output logic [15:0]       rsp_block_align,
   output logic [15:0]       rsp_sample_bits,
   output logic [31:0]       rsp_data_length,
   output logic              rsp_end_of_run
);

   // status fields arrive with the status action in the queue
   logic        vld_ff, vld_in, did_ff, did_in;
   logic        kind_ff, kind_in;
   logic [7:0]  smp_ff, smp_in;
   logic [2:0]  sts_ff, sts_in;
   logic [15:0] ch_ff, ch_in, al_ff, al_in, bi_ff, bi_in;
   logic [31:0] ra_ff, ra_in, ln_ff, ln_in;
   logic        free, sample_now;

   assign free = !vld_ff || !rsp_stall;
   // a head with both a sample and a status sends the sample first
   assign sample_now = q_head.emit_sample && !did_ff;

   always_comb begin
      vld_in = vld_ff && rsp_stall; did_in = did_ff; q_pop = 1'b0;
      kind_in = kind_ff; smp_in = smp_ff; sts_in = sts_ff; ch_in = ch_ff;
      ra_in = ra_ff; al_in = al_ff; bi_in = bi_ff; ln_in = ln_ff;
      if (free && !q_empty) begin
         vld_in = 1'b1;
         if (sample_now) begin
            kind_in = 1'b0; smp_in = q_head.sample; sts_in = '0; ch_in = '0;
            ra_in = '0; al_in = '0; bi_in = '0; ln_in = '0;
            if (q_head.emit_status) did_in = 1'b1;
            else q_pop = 1'b1;
         end else begin
            kind_in = 1'b1; smp_in = '0; sts_in = q_head.status; ch_in = q_head.channels;
            ra_in = q_head.rate; al_in = q_head.align; bi_in = q_head.bits;
            ln_in = q_head.dlen;
            did_in = 1'b0; q_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; did_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in; did_ff <= did_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; smp_ff <= smp_in; sts_ff <= sts_in; ch_ff <= ch_in;
      ra_ff <= ra_in; al_ff <= al_in; bi_ff <= bi_in; ln_ff <= ln_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_item_kind = kind_ff;
   assign rsp_sample_byte = smp_ff;
   assign rsp_status = sts_ff;
   assign rsp_channel_count = ch_ff;
   assign rsp_sample_rate = ra_ff;
   assign rsp_block_align = al_ff;
   assign rsp_sample_bits = bi_ff;
   assign rsp_data_length = ln_ff;
   assign rsp_end_of_run = kind_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_byte) && $stable(rsp_status))
      else $error("output changed under stall");
   a_split: assert property (@(posedge clock) disable iff (reset)
      did_ff |-> !q_empty) else $error("split item lost");
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> free) else $error("pop without room");

endmodule

// ----- design/wave_pcm_chunk_parser_core.sv -----
// top level of the riff wave pcm chunk parser
// Usage:
//   req_ channel carries one file byte per item plus a final-byte flag.
//   rsp_ channel returns sample bytes (item_kind 0) from the data chunk and,
//   for the byte flagged final, one status item (item_kind 1, end_of_run 1)
//   with the captured fmt fields and the data length.
//   Throughput is one byte per cycle while req_stall is low. At the data
//   chunk header the front stalls while a shift-add multiplier checks the
//   byte rate and a restoring divider checks the data length against the
//   alignment. An accepted byte's result passes through the action queue and
//   then the output register; a final byte that also carries a sample gives
//   two items, the sample first and then the status. A final byte that ends
//   a data chunk header gets its status once the check is done.
//   A four-entry action queue sits between parser and output register; when
//   rsp_stall holds the queue fills and then req_stall rises.
//   Each status action carries its own fmt fields through the queue.
//   Reset (synchronous, active high) returns to waiting for the RIFF tag and
//   empties the queue. After each final byte the parser restarts by itself.
module wave_pcm_chunk_parser_core #(
   parameter int FMT_MIN_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_sample_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_sample_bits,
   output logic [31:0] rsp_data_length,
   output logic        rsp_end_of_run
);

   wpcm_pkg::act_type act, head;
   logic act_valid, full, empty, pop;

   wpcm_front #(.FMT_MIN_BYTES(FMT_MIN_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_final_byte,
      .act_valid, .act_full(full), .act
   );

   wpcm_queue #(.DEPTH(4)) u_queue (
      .clock, .reset, .push(act_valid), .push_act(act), .full,
      .pop, .empty, .head
   );

   wpcm_back u_back (
      .clock, .reset, .q_empty(empty), .q_head(head), .q_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_item_kind, .rsp_sample_byte, .rsp_status,
      .rsp_channel_count, .rsp_sample_rate, .rsp_block_align, .rsp_sample_bits,
      .rsp_data_length, .rsp_end_of_run
   );

endmodule
